@@ design/lroa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lroa_pkg;

  // field widths
  localparam int RANGE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CMD_W   = 17;
  localparam int IDX_W   = 8;
  localparam int CFG_IDX_W = 3;

  // packed channel widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_TH   = 3'd0,
    REG_DETECT_TH = 3'd1,
    REG_REVERSE   = 3'd2,
    REG_TURN      = 3'd3,
    REG_CRUISE    = 3'd4,
    REG_GOAL      = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [CFG_W-1:0] NEAR_TH_RST   = 16'd1350;
  localparam logic [CFG_W-1:0] DETECT_TH_RST = 16'd3500;
  localparam logic [CFG_W-1:0] REVERSE_RST   = 16'd800;
  localparam logic [CFG_W-1:0] TURN_RST      = 16'd1500;
  localparam logic [CFG_W-1:0] CRUISE_RST    = 16'd600;

  // obstacle case codes
  typedef enum logic [2:0] {
    CASE_ALL         = 3'd0,
    CASE_FRONT       = 3'd1,
    CASE_RIGHT       = 3'd2,
    CASE_LEFT        = 3'd3,
    CASE_FRONT_RIGHT = 3'd4,
    CASE_FRONT_LEFT  = 3'd5,
    CASE_LEFT_RIGHT  = 3'd6,
    CASE_UNKNOWN     = 3'd7
  } case_code_t;

endpackage : lroa_pkg

`default_nettype wire

@@ design/lidar_region_obstacle_avoider_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// result: registered; it appears in the cycle after the transfer of the last sample of a scan, unless goal is set
// throughput: one sample per cycle; the output register is reloaded in the same cycle
//   it is taken, so a stalled result only holds off input while out_tready is low
// reset: synchronous, active low; clears region minimums to all ones, sample index,
//   detect flag and output valid, and loads the register defaults

module lidar_region_obstacle_avoider_core
  import lroa_pkg::*;
#(
  parameter int RIGHT_END = 60,
  parameter int FRONT_END = 120
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  // sample stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] range_mm
  input  wire logic                   in_tlast,   // last
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [16:0] linear_cmd, [33:17] angular_cmd,
                                                  // [39:34] zero
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // [0] act, [3:1] case_code
  output logic                        out_tlast   // scan_done
);

  localparam logic [IDX_W-1:0] RightEndIdx = IDX_W'(RIGHT_END);
  localparam logic [IDX_W-1:0] FrontEndIdx = IDX_W'(FRONT_END);

  // configuration registers
  logic [CFG_W-1:0] near_th_r, detect_th_r, reverse_r, turn_r, cruise_r;
  logic             goal_r;

  // per-scan state
  logic [RANGE_W-1:0] right_min_r, front_min_r, left_min_r;
  logic [RANGE_W-1:0] right_min_nxt, front_min_nxt, left_min_nxt;
  logic               below_detect_r, below_detect_nxt;
  logic [IDX_W-1:0]   sample_index_r, sample_index_nxt;

  // output register
  logic               out_valid_r;
  logic               act_r;
  case_code_t         code_r;
  logic [CMD_W-1:0]   lin_r, ang_r;

  logic               in_xfer;
  logic [RANGE_W-1:0] range_mm;
  logic               fb, fc, lb, lc, rb, rc;
  case_code_t         code_nxt;
  logic [CMD_W-1:0]   lin_nxt, ang_nxt;
  logic [CMD_W-1:0]   rev_neg, turn_neg, turn_pos, cruise_pos;

  assign range_mm  = in_tdata[RANGE_W-1:0];
  assign in_tready = ~out_valid_r | out_tready;
  assign in_xfer   = in_tvalid & in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_th_r   <= NEAR_TH_RST;
      detect_th_r <= DETECT_TH_RST;
      reverse_r   <= REVERSE_RST;
      turn_r      <= TURN_RST;
      cruise_r    <= CRUISE_RST;
      goal_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_TH:   near_th_r   <= cfg_wdata;
        REG_DETECT_TH: detect_th_r <= cfg_wdata;
        REG_REVERSE:   reverse_r   <= cfg_wdata;
        REG_TURN:      turn_r      <= cfg_wdata;
        REG_CRUISE:    cruise_r    <= cfg_wdata;
        REG_GOAL:      goal_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // region minimum and detect update for the current sample
  always_comb begin
    right_min_nxt    = right_min_r;
    front_min_nxt    = front_min_r;
    left_min_nxt     = left_min_r;
    sample_index_nxt = sample_index_r;
    if (sample_index_r < RightEndIdx) begin
      if (range_mm < right_min_r) right_min_nxt = range_mm;
    end else if (sample_index_r < FrontEndIdx) begin
      if (range_mm < front_min_r) front_min_nxt = range_mm;
    end else begin
      if (range_mm < left_min_r) left_min_nxt = range_mm;
    end
    if (sample_index_r < FrontEndIdx) sample_index_nxt = sample_index_r + 1'b1;
    below_detect_nxt = below_detect_r | (range_mm < detect_th_r);
  end

  // region classification; equal to the threshold is neither blocked nor clear
  assign fb = front_min_nxt < near_th_r;
  assign fc = front_min_nxt > near_th_r;
  assign lb = left_min_nxt  < near_th_r;
  assign lc = left_min_nxt  > near_th_r;
  assign rb = right_min_nxt < near_th_r;
  assign rc = right_min_nxt > near_th_r;

  assign rev_neg    = CMD_W'(-{1'b0, reverse_r});
  assign turn_neg   = CMD_W'(-{1'b0, turn_r});
  assign turn_pos   = {1'b0, turn_r};
  assign cruise_pos = {1'b0, cruise_r};

  // eight-case command table, first match wins
  always_comb begin
    if (fb && lb && rb) begin
      code_nxt = CASE_ALL;         lin_nxt = rev_neg;     ang_nxt = turn_pos;
    end else if (fb && lc && rc) begin
      code_nxt = CASE_FRONT;       lin_nxt = '0;          ang_nxt = turn_pos;
    end else if (fc && lc && rb) begin
      code_nxt = CASE_RIGHT;       lin_nxt = cruise_pos;  ang_nxt = '0;
    end else if (fc && lb && rc) begin
      code_nxt = CASE_LEFT;        lin_nxt = cruise_pos;  ang_nxt = '0;
    end else if (fb && lc && rb) begin
      code_nxt = CASE_FRONT_RIGHT; lin_nxt = '0;          ang_nxt = turn_neg;
    end else if (fb && lb && rc) begin
      code_nxt = CASE_FRONT_LEFT;  lin_nxt = '0;          ang_nxt = turn_pos;
    end else if (fc && lb && rb) begin
      code_nxt = CASE_LEFT_RIGHT;  lin_nxt = rev_neg;     ang_nxt = turn_pos;
    end else begin
      code_nxt = CASE_UNKNOWN;     lin_nxt = cruise_pos;  ang_nxt = turn_neg;
    end
  end

  // per-scan state, reloaded after the last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_min_r    <= '1;
      front_min_r    <= '1;
      left_min_r     <= '1;
      below_detect_r <= 1'b0;
      sample_index_r <= '0;
    end else if (in_xfer) begin
      if (in_tlast) begin
        right_min_r    <= '1;
        front_min_r    <= '1;
        left_min_r     <= '1;
        below_detect_r <= 1'b0;
        sample_index_r <= '0;
      end else begin
        right_min_r    <= right_min_nxt;
        front_min_r    <= front_min_nxt;
        left_min_r     <= left_min_nxt;
        below_detect_r <= below_detect_nxt;
        sample_index_r <= sample_index_nxt;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_xfer & in_tlast & ~goal_r;
    end
  end

  // output payload; fields are zero when nothing fell below detect
  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      act_r  <= below_detect_nxt;
      code_r <= below_detect_nxt ? code_nxt : CASE_ALL;
      lin_r  <= below_detect_nxt ? lin_nxt  : '0;
      ang_r  <= below_detect_nxt ? ang_nxt  : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*CMD_W){1'b0}}, ang_r, lin_r};
  assign out_tuser  = {code_r, act_r};
  assign out_tlast  = 1'b1;

  // a sample that does not end a scan never produces a result
  a_no_result_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tlast) |=> !out_tvalid)
    else $error("result raised by a sample inside a scan");

  // an end of scan produces a result unless the goal is reached
  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast && !goal_r) |=> out_tvalid)
    else $error("end of scan produced no result");

  // a result without action carries zero fields
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !act_r) |-> (code_r == CASE_ALL && lin_r == '0 && ang_r == '0))
    else $error("non-acting result carries nonzero fields");

  // sample index saturates at the front region end
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_index_r <= FrontEndIdx) || (sample_index_r == '0))
    else $error("sample index past front region end");

endmodule : lidar_region_obstacle_avoider_core

`default_nettype wire

@@ test/lidar_region_obstacle_avoider_core_tb.sv @@
`timescale 1ns / 1ps

module lidar_region_obstacle_avoider_core_tb;
  import lroa_pkg::*;

  localparam int RIGHT_END       = 60;
  localparam int FRONT_END       = 120;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int SCANS_PER_PHASE = 3;
  localparam int HOLD_CYCLES     = 300;

  // one end-of-scan command as it leaves the block
  typedef struct packed {
    logic                    act;
    case_code_t              code;
    logic signed [CMD_W-1:0] lin;
    logic signed [CMD_W-1:0] ang;
    logic                    done;
  } scan_cmd_t;

  // directed scan: length, the minimum placed in each region, optional fixed answer
  typedef struct packed {
    logic [9:0]  len;
    logic [15:0] r_mm;
    logic [15:0] f_mm;
    logic [15:0] l_mm;
    logic        typed;
    scan_cmd_t   want;
  } scan_row_t;

  typedef struct packed {
    logic [15:0] near_mm;
    logic [15:0] detect_mm;
    logic [15:0] rev_spd;
    logic [15:0] turn_spd;
    logic [15:0] cruise_spd;
    logic        goal_flag;
  } setting_t;

  localparam scan_cmd_t NO_ACT = '{1'b0, CASE_ALL, 17'sd0, 17'sd0, 1'b1};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // predictor copy of registers and per-scan state
  logic [15:0] th_near, th_detect, spd_reverse, spd_turn, spd_cruise;
  logic        goal_set;
  logic [15:0] rgt_low, frt_low, lft_low;
  logic        saw_close;
  int          pos_idx;

  scan_cmd_t   pending_cmds[$];
  logic [15:0] scan_buf[$];
  scan_row_t   rows[9];
  setting_t    settings[PHASES];

  int mismatches   = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int scans_sent   = 0;
  int cycles       = 0;
  bit held_off     = 1'b0;

  lidar_region_obstacle_avoider_core #(
    .RIGHT_END(RIGHT_END),
    .FRONT_END(FRONT_END)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] range_mm
    .in_tlast  (in_tlast),   // last
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [16:0] linear_cmd, [33:17] angular_cmd, [39:34] zero
    .out_tuser (out_tuser),  // [0] act, [3:1] case_code
    .out_tlast (out_tlast)   // scan_done
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands outstanding", cycles,
               pending_cmds.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_scan();
    rgt_low   = 16'hFFFF;
    frt_low   = 16'hFFFF;
    lft_low   = 16'hFFFF;
    saw_close = 1'b0;
    pos_idx   = 0;
  endfunction

  // fold one sample into the region minimums; returns 1 when a command is due
  function automatic bit fold_sample(input logic [15:0] r, input bit is_last,
                                     output scan_cmd_t cmd);
    bit fb, fc, lb, lc, rb, rc;
    cmd = NO_ACT;
    if (pos_idx < RIGHT_END) begin
      if (r < rgt_low) rgt_low = r;
    end else if (pos_idx < FRONT_END) begin
      if (r < frt_low) frt_low = r;
    end else begin
      if (r < lft_low) lft_low = r;
    end
    if (pos_idx < FRONT_END) pos_idx++;
    if (r < th_detect) saw_close = 1'b1;
    if (!is_last) return 1'b0;
    if (goal_set) begin
      clear_scan();
      return 1'b0;
    end
    // strict compares: a minimum equal to the threshold is neither blocked nor clear
    fb = frt_low < th_near;  fc = frt_low > th_near;
    lb = lft_low < th_near;  lc = lft_low > th_near;
    rb = rgt_low < th_near;  rc = rgt_low > th_near;
    if (saw_close) begin
      cmd.act = 1'b1;
      if (fb && lb && rb) begin
        cmd.code = CASE_ALL;
        cmd.lin  = -$signed({1'b0, spd_reverse});
        cmd.ang  = $signed({1'b0, spd_turn});
      end else if (fb && lc && rc) begin
        cmd.code = CASE_FRONT;
        cmd.lin  = '0;
        cmd.ang  = $signed({1'b0, spd_turn});
      end else if (fc && lc && rb) begin
        cmd.code = CASE_RIGHT;
        cmd.lin  = $signed({1'b0, spd_cruise});
        cmd.ang  = '0;
      end else if (fc && lb && rc) begin
        cmd.code = CASE_LEFT;
        cmd.lin  = $signed({1'b0, spd_cruise});
        cmd.ang  = '0;
      end else if (fb && lc && rb) begin
        cmd.code = CASE_FRONT_RIGHT;
        cmd.lin  = '0;
        cmd.ang  = -$signed({1'b0, spd_turn});
      end else if (fb && lb && rc) begin
        cmd.code = CASE_FRONT_LEFT;
        cmd.lin  = '0;
        cmd.ang  = $signed({1'b0, spd_turn});
      end else if (fc && lb && rb) begin
        cmd.code = CASE_LEFT_RIGHT;
        cmd.lin  = -$signed({1'b0, spd_reverse});
        cmd.ang  = $signed({1'b0, spd_turn});
      end else begin
        cmd.code = CASE_UNKNOWN;
        cmd.lin  = $signed({1'b0, spd_cruise});
        cmd.ang  = -$signed({1'b0, spd_turn});
      end
    end
    clear_scan();
    return 1'b1;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_NEAR_TH:   th_near     = val;
      REG_DETECT_TH: th_detect   = val;
      REG_REVERSE:   spd_reverse = val;
      REG_TURN:      spd_turn    = val;
      REG_CRUISE:    spd_cruise  = val;
      REG_GOAL:      goal_set    = val[0];
      default: ;
    endcase
  endtask

  // drive the samples in scan_buf, the last one with tlast
  task automatic send_scan(input bit typed, input scan_cmd_t want);
    scan_cmd_t cmd;
    int        gap, n;
    bit        idle_on;
    idle_on = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < scan_buf.size(); i++) begin
      gap = 0;
      if (idle_on) begin
        n = $urandom_range(0, 19);
        if (n >= 19) gap = $urandom_range(8, 30);
        else if (n >= 13) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= scan_buf[i];
      in_tlast  <= (i == scan_buf.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (fold_sample(scan_buf[i], i == scan_buf.size() - 1, cmd))
        pending_cmds.push_back(typed ? want : cmd);
      samples_sent++;
    end
    scans_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    scan_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no scan pending", {out_tuser, out_tdata[33:0]}, '0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_tuser[0] !== want.act)
          report_mismatch("act", out_tuser[0], want.act);
        if (out_tuser[3:1] !== want.code)
          report_mismatch("case code", out_tuser[3:1], want.code);
        if (out_tdata[16:0] !== want.lin)
          report_mismatch("linear command", out_tdata[16:0], want.lin);
        if (out_tdata[33:17] !== want.ang)
          report_mismatch("angular command", out_tdata[33:17], want.ang);
        if (out_tdata[39:34] !== '0)
          report_mismatch("tdata padding", out_tdata[39:34], '0);
        if (out_tlast !== want.done)
          report_mismatch("scan done", out_tlast, want.done);
      end
      results_seen++;
    end
  end

  // result side: random stalls, long ready stretches, one long hold-off
  initial begin
    int n, span;
    bit rdy;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 2) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      n = $urandom_range(0, 19);
      if (n < 4) begin
        rdy = 1'b0; span = $urandom_range(1, 3);
      end else if (n == 4) begin
        rdy = 1'b0; span = $urandom_range(8, 40);
      end else if (n < 8) begin
        rdy = 1'b1; span = $urandom_range(60, 150);
      end else begin
        rdy = 1'b1; span = $urandom_range(1, 6);
      end
      out_tready <= rdy;
      repeat (span) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int          len, k, cnt, cls, j, rl;
    logic [15:0] floor_v[3];
    int          lo[3], hi[3];

    th_near     = NEAR_TH_RST;
    th_detect   = DETECT_TH_RST;
    spd_reverse = REVERSE_RST;
    spd_turn    = TURN_RST;
    spd_cruise  = CRUISE_RST;
    goal_set    = 1'b0;
    clear_scan();

    // directed scans, all at reset register values
    rows[0] = '{10'd1,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_ACT};
    rows[1] = '{10'd1,   16'd0,    16'hFFFF, 16'hFFFF, 1'b1,
                '{1'b1, CASE_RIGHT, 17'sd600, 17'sd0, 1'b1}};
    rows[2] = '{10'd121, 16'd0,    16'd0,    16'd0,    1'b1,
                '{1'b1, CASE_ALL, -17'sd800, 17'sd1500, 1'b1}};
    // right minimum sitting on the near threshold
    rows[3] = '{10'd1,   16'd1350, 16'hFFFF, 16'hFFFF, 1'b0, NO_ACT};
    // nothing strictly below detect
    rows[4] = '{10'd1,   16'd3500, 16'hFFFF, 16'hFFFF, 1'b1, NO_ACT};
    // just below detect, every region clear
    rows[5] = '{10'd1,   16'd3499, 16'hFFFF, 16'hFFFF, 1'b0, NO_ACT};
    // scans that leave the left region empty
    rows[6] = '{10'd61,  16'd2000, 16'd100,  16'hFFFF, 1'b0, NO_ACT};
    rows[7] = '{10'd61,  16'd100,  16'd100,  16'hFFFF, 1'b0, NO_ACT};
    // long scan, left minimum on a sample past the index saturation
    rows[8] = '{10'd122, 16'd2000, 16'd2000, 16'd100,  1'b0, NO_ACT};

    settings[0] = '{NEAR_TH_RST, DETECT_TH_RST, REVERSE_RST, TURN_RST, CRUISE_RST, 1'b0};
    settings[1] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
    settings[2] = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
    settings[3] = '{NEAR_TH_RST, DETECT_TH_RST, REVERSE_RST, TURN_RST, CRUISE_RST, 1'b1};
    for (int p = 4; p < 7; p++)
      settings[p] = '{16'($urandom_range(1, 8000)), 16'($urandom_range(0, 20000)),
                      16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
    settings[7] = '{16'hFFFE, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      scan_buf.delete();
      len = rows[r].len;
      for (int i = 0; i < len; i++) scan_buf.push_back(16'hFFFF);
      // each region's minimum goes on its last sample
      rl = ((len < RIGHT_END) ? len : RIGHT_END) - 1;
      scan_buf[rl] = rows[r].r_mm;
      if (len > RIGHT_END) scan_buf[((len < FRONT_END) ? len : FRONT_END) - 1] = rows[r].f_mm;
      if (len > FRONT_END) scan_buf[len - 1] = rows[r].l_mm;
      send_scan(rows[r].typed, rows[r].want);
    end

    // random short scans under a series of register settings
    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      write_reg(REG_NEAR_TH,   settings[p].near_mm);
      write_reg(REG_DETECT_TH, settings[p].detect_mm);
      write_reg(REG_REVERSE,   settings[p].rev_spd);
      write_reg(REG_TURN,      settings[p].turn_spd);
      write_reg(REG_CRUISE,    settings[p].cruise_spd);
      write_reg(REG_GOAL,      {15'($urandom), settings[p].goal_flag});
      cfg_we <= 1'b0;

      for (int s = 0; s < SCANS_PER_PHASE; s++) begin
        k = $urandom_range(0, 19);
        if (k < 15) len = $urandom_range(1, 4);
        else len = $urandom_range(5, 8);
        scan_buf.delete();
        if ($urandom_range(0, 6) == 0) begin
          // noise scan
          for (int i = 0; i < len; i++) scan_buf.push_back(16'($urandom));
        end else begin
          // per region: minimum below, on or above the near threshold
          for (int g = 0; g < 3; g++) begin
            cls = $urandom_range(0, 9);
            if (cls < 5 && th_near > 0)
              floor_v[g] = 16'($urandom_range(0, th_near - 1));
            else if (cls > 6 && th_near < 16'hFFFF)
              floor_v[g] = 16'($urandom_range(th_near + 1, 65535));
            else
              floor_v[g] = th_near;
          end
          lo = '{0, RIGHT_END, FRONT_END};
          hi = '{RIGHT_END, FRONT_END, len};
          for (int i = 0; i < len; i++) begin
            j = (i < RIGHT_END) ? 0 : (i < FRONT_END) ? 1 : 2;
            scan_buf.push_back(16'($urandom_range(floor_v[j], 65535)));
          end
          for (int g = 0; g < 3; g++) begin
            cnt = ((len < hi[g]) ? len : hi[g]) - lo[g];
            if (cnt > 0) scan_buf[lo[g] + $urandom_range(0, cnt - 1)] = floor_v[g];
          end
        end
        send_scan(1'b0, NO_ACT);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d scans of %0d samples sent, %0d end-of-scan commands checked",
             scans_sent, samples_sent, results_seen);
    $display("%0d register settings incl. threshold extremes and goal hold, one long stall",
             PHASES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ lidar_region_obstacle_avoider_core.f @@
design/lroa_pkg.sv
design/lidar_region_obstacle_avoider_core.sv
test/lidar_region_obstacle_avoider_core_tb.sv
